// ----- hw/rtl/http_response_chunked_decoder_macros.svh -----
// ============================================================================
// HTTP response chunked decoder assertion macros
// Concurrent assertion helpers clocked on aclk and held off during reset.
// ============================================================================
`ifndef HTTP_RESPONSE_CHUNKED_DECODER_MACROS_SVH
`define HTTP_RESPONSE_CHUNKED_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define HRCD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");
// condition that must never be true out of reset
`define HRCD_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define HRCD_ASSERT(label, prop)
`define HRCD_NEVER(label, cond)
`endif

`endif

// ----- hw/rtl/hrcd_pkg.sv -----
// ============================================================================
// hrcd_pkg
// Types, character constants and lookup functions of the HTTP response
// chunked decoder.
// ============================================================================
package hrcd_pkg;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_PLAIN   = 7'b0000010,
        PH_SIZE    = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_TRAILER = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_BAD     = 7'b1000000
    } phase_t;

    // closing status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_HDR_END  = 2'd1,
        ST_NOT_200     = 2'd2
    } status_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_LIMIT  = 1'd1;

    localparam logic [23:0] BODY_LIMIT_RST = 24'd65535;
    localparam logic [24:0] RAW_LIMIT_RST  = 25'd80281;

    // characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [3:0] STATUS_LEN     = 4'd12;
    localparam logic [3:0] STATUS_ALT_POS = 4'd7;   // the minor version digit
    localparam logic [4:0] PATTERN_LEN    = 5'd26;
    localparam logic [30:0] SIZE_MAX      = 31'h7FFF_FFFF;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // one result item
    typedef struct packed {
        logic        was_chunked;
        logic [23:0] body_length;
        status_t     status_code;
        logic [7:0]  body_byte;
        logic        is_final;
    } result_t;

    // expected status line "HTTP/1.1 200"
    function automatic logic [7:0] status_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "H";
            4'd1:    ch = "T";
            4'd2:    ch = "T";
            4'd3:    ch = "P";
            4'd4:    ch = "/";
            4'd5:    ch = "1";
            4'd6:    ch = ".";
            4'd7:    ch = "1";
            4'd8:    ch = " ";
            4'd9:    ch = "2";
            4'd10:   ch = "0";
            4'd11:   ch = "0";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // header text "Transfer-Encoding: chunked"
    function automatic logic [7:0] pattern_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "T";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "E";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            5'd17:   ch = ":";
            5'd18:   ch = " ";
            5'd19:   ch = "c";
            5'd20:   ch = "h";
            5'd21:   ch = "u";
            5'd22:   ch = "n";
            5'd23:   ch = "k";
            5'd24:   ch = "e";
            5'd25:   ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/http_response_chunked_decoder.sv -----
// ============================================================================
// http_response_chunked_decoder
// Byte-wide HTTP response parser that checks the status line, finds the end
// of the header and delivers the body, plain or chunk decoded.
// ============================================================================
// One raw byte is taken per cycle and parsed in the same cycle into a
// 4-entry result queue; results leave at one per cycle while m_tready is
// high. A byte marked with tlast adds a closing status result, so such a
// byte yields up to two results, and s_tready drops while fewer than two
// queue slots are free. Without output back-pressure the sustained rate is
// one byte per cycle, and each closing result needs an output slot of its own.
// Configuration writes are always accepted and apply to the following bytes.
module http_response_chunked_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // raw response bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,   // in_last
    // decoded results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [7:0] body_byte,
                                                     // [9:8] status_code,
                                                     // [33:10] body_length,
                                                     // [34] was_chunked,
                                                     // [39:35] zero
    output logic                          m_tlast,   // is_final
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hrcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [24:0]                   cfg_data
);
    import hrcd_pkg::*;

    // configuration registers
    logic [23:0] body_limit_reg;
    logic [24:0] raw_limit_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [1:0]  crlf_cnt_reg, crlf_cnt_next;
    logic [3:0]  status_idx_reg, status_idx_next;
    logic        status_bad_reg, status_bad_next;
    logic [4:0]  pat_idx_reg, pat_idx_next;
    logic        chunked_reg, chunked_next;
    logic [30:0] size_acc_reg, size_acc_next;
    logic        hex_stop_reg, hex_stop_next;
    logic        prev_cr_reg, prev_cr_next;
    logic [30:0] chunk_rem_reg, chunk_rem_next;
    logic [1:0]  trail_reg, trail_next;
    logic [24:0] raw_cnt_reg, raw_cnt_next;
    logic [23:0] deliv_cnt_reg, deliv_cnt_next;

    // result queue
    result_t              res_buf_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg;

    logic       s_fire, m_fire;
    logic       emit;
    logic [1:0] push_n;
    logic [4:0] hex_d;
    logic       crlf_want_hit;
    status_t    close_st;
    result_t    body_rec, final_rec, rec0, rec1;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign s_tready  = (res_cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign cfg_ready = 1'b1;
    assign hex_d     = hex_decode(s_tdata);
    assign crlf_want_hit = (s_tdata == (crlf_cnt_reg[0] ? CH_LF : CH_CR));

    // per-byte parse and result building
    always_comb begin
        phase_next      = phase_reg;
        crlf_cnt_next   = crlf_cnt_reg;
        status_idx_next = status_idx_reg;
        status_bad_next = status_bad_reg;
        pat_idx_next    = pat_idx_reg;
        chunked_next    = chunked_reg;
        size_acc_next   = size_acc_reg;
        hex_stop_next   = hex_stop_reg;
        prev_cr_next    = prev_cr_reg;
        chunk_rem_next  = chunk_rem_reg;
        trail_next      = trail_reg;
        raw_cnt_next    = raw_cnt_reg;
        deliv_cnt_next  = deliv_cnt_reg;
        emit            = 1'b0;

        if (s_fire && (raw_cnt_reg < raw_limit_reg)) begin
            raw_cnt_next = raw_cnt_reg + 25'd1;
            case (phase_reg)
                PH_HEADER: begin
                    // status line check
                    if (status_idx_reg < STATUS_LEN) begin
                        if (!((s_tdata == status_char(status_idx_reg)) ||
                              (status_idx_reg == STATUS_ALT_POS && s_tdata == CH_ZERO))) begin
                            status_bad_next = 1'b1;
                        end
                        status_idx_next = status_idx_reg + 4'd1;
                    end
                    // transfer-encoding text search
                    if (!chunked_reg) begin
                        if (pat_idx_reg < PATTERN_LEN &&
                            s_tdata == pattern_char(pat_idx_reg)) begin
                            pat_idx_next = pat_idx_reg + 5'd1;
                            if (pat_idx_reg == PATTERN_LEN - 5'd1) begin
                                chunked_next = 1'b1;
                            end
                        end else begin
                            pat_idx_next = (s_tdata == CH_T) ? 5'd1 : 5'd0;
                        end
                    end
                    // header end search
                    if (crlf_want_hit) begin
                        if (crlf_cnt_reg == 2'd3) begin
                            crlf_cnt_next = 2'd0;
                            if (status_idx_next == STATUS_LEN && !status_bad_next) begin
                                phase_next = chunked_next ? PH_SIZE : PH_PLAIN;
                            end else begin
                                phase_next = PH_BAD;
                            end
                        end else begin
                            crlf_cnt_next = crlf_cnt_reg + 2'd1;
                        end
                    end else begin
                        crlf_cnt_next = (s_tdata == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
                PH_PLAIN: begin
                    if (deliv_cnt_reg < body_limit_reg) begin
                        deliv_cnt_next = deliv_cnt_reg + 24'd1;
                        emit           = 1'b1;
                    end
                end
                PH_SIZE: begin
                    if (prev_cr_reg && s_tdata == CH_LF) begin
                        // end of size line
                        if (size_acc_reg == 31'd0) begin
                            phase_next = PH_DONE;
                        end else begin
                            chunk_rem_next = size_acc_reg;
                            phase_next     = PH_DATA;
                        end
                        size_acc_next = 31'd0;
                        hex_stop_next = 1'b0;
                        prev_cr_next  = 1'b0;
                    end else begin
                        prev_cr_next = (s_tdata == CH_CR);
                        if (!hex_stop_reg) begin
                            if (!hex_d[4]) begin
                                hex_stop_next = 1'b1;
                            end else if (|size_acc_reg[30:27]) begin
                                size_acc_next = SIZE_MAX;
                            end else begin
                                size_acc_next = {size_acc_reg[26:0], hex_d[3:0]};
                            end
                        end
                    end
                end
                PH_DATA: begin
                    if (deliv_cnt_reg < body_limit_reg) begin
                        deliv_cnt_next = deliv_cnt_reg + 24'd1;
                        emit           = 1'b1;
                    end
                    chunk_rem_next = chunk_rem_reg - 31'd1;
                    if (chunk_rem_reg == 31'd1) begin
                        trail_next = 2'd2;
                        phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    // the two bytes after chunk data are skipped unchecked
                    if (trail_reg != 2'd0) begin
                        trail_next = trail_reg - 2'd1;
                    end
                    if (trail_reg <= 2'd1) begin
                        phase_next = PH_SIZE;
                    end
                end
                default: begin
                end
            endcase
        end

        // body byte result
        body_rec.is_final    = 1'b0;
        body_rec.body_byte   = s_tdata;
        body_rec.status_code = ST_OK;
        body_rec.body_length = deliv_cnt_next;
        body_rec.was_chunked = chunked_next;

        // closing result
        if (phase_next == PH_HEADER) begin
            close_st = ST_NO_HDR_END;
        end else if (phase_next == PH_BAD) begin
            close_st = ST_NOT_200;
        end else begin
            close_st = ST_OK;
        end
        final_rec.is_final    = 1'b1;
        final_rec.body_byte   = 8'd0;
        final_rec.status_code = close_st;
        final_rec.body_length = deliv_cnt_next;
        final_rec.was_chunked = (close_st == ST_OK) && chunked_next;

        rec0   = emit ? body_rec : final_rec;
        rec1   = final_rec;
        push_n = 2'd0;
        if (s_fire) begin
            push_n = {1'b0, emit} + {1'b0, s_tlast};
        end

        // end of response restarts the parser
        if (s_fire && s_tlast) begin
            phase_next      = PH_HEADER;
            crlf_cnt_next   = 2'd0;
            status_idx_next = 4'd0;
            status_bad_next = 1'b0;
            pat_idx_next    = 5'd0;
            chunked_next    = 1'b0;
            size_acc_next   = 31'd0;
            hex_stop_next   = 1'b0;
            prev_cr_next    = 1'b0;
            chunk_rem_next  = 31'd0;
            trail_next      = 2'd0;
            raw_cnt_next    = 25'd0;
            deliv_cnt_next  = 24'd0;
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_limit_reg <= BODY_LIMIT_RST;
            raw_limit_reg  <= RAW_LIMIT_RST;
            phase_reg      <= PH_HEADER;
            crlf_cnt_reg   <= 2'd0;
            status_idx_reg <= 4'd0;
            status_bad_reg <= 1'b0;
            pat_idx_reg    <= 5'd0;
            chunked_reg    <= 1'b0;
            size_acc_reg   <= 31'd0;
            hex_stop_reg   <= 1'b0;
            prev_cr_reg    <= 1'b0;
            chunk_rem_reg  <= 31'd0;
            trail_reg      <= 2'd0;
            raw_cnt_reg    <= 25'd0;
            deliv_cnt_reg  <= 24'd0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            res_cnt_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_BODY_LIMIT) begin
                    body_limit_reg <= cfg_data[23:0];
                end else if (cfg_index == REG_RAW_LIMIT) begin
                    raw_limit_reg <= cfg_data;
                end
            end
            phase_reg      <= phase_next;
            crlf_cnt_reg   <= crlf_cnt_next;
            status_idx_reg <= status_idx_next;
            status_bad_reg <= status_bad_next;
            pat_idx_reg    <= pat_idx_next;
            chunked_reg    <= chunked_next;
            size_acc_reg   <= size_acc_next;
            hex_stop_reg   <= hex_stop_next;
            prev_cr_reg    <= prev_cr_next;
            chunk_rem_reg  <= chunk_rem_next;
            trail_reg      <= trail_next;
            raw_cnt_reg    <= raw_cnt_next;
            deliv_cnt_reg  <= deliv_cnt_next;
            wr_ptr_reg     <= wr_ptr_reg + RES_PTR_W'(push_n);
            rd_ptr_reg     <= rd_ptr_reg + RES_PTR_W'(m_fire);
            res_cnt_reg    <= res_cnt_reg + RES_CNT_W'(push_n) - RES_CNT_W'(m_fire);
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            res_buf_reg[wr_ptr_reg] <= rec0;
        end
        if (push_n == 2'd2) begin
            res_buf_reg[wr_ptr_reg + RES_PTR_W'(1)] <= rec1;
        end
    end

    // output side
    result_t head;
    assign head     = res_buf_reg[rd_ptr_reg];
    assign m_tvalid = (res_cnt_reg != '0);
    assign m_tlast  = head.is_final;
    assign m_tdata  = {5'd0, head.was_chunked, head.body_length,
                       head.status_code, head.body_byte};

    `include "http_response_chunked_decoder_macros.svh"

    // queue never holds more than its depth
    `HRCD_NEVER(a_res_overflow, res_cnt_reg > RES_CNT_W'(RES_DEPTH))
    // a byte marked last restarts the parser
    `HRCD_ASSERT(a_last_restarts, (s_fire && s_tlast) |=> (phase_reg == PH_HEADER && raw_cnt_reg == 25'd0 && deliv_cnt_reg == 24'd0))
    // status index stops at the length of the status text
    `HRCD_NEVER(a_status_idx_range, status_idx_reg > STATUS_LEN)
    // body output only after a good header
    `HRCD_ASSERT(a_body_after_header, (s_fire && emit) |-> (phase_reg == PH_PLAIN || phase_reg == PH_DATA))

endmodule
